@@ src/ftl_pkg.sv @@
// Shared constants for the frequency to LCD text writer.
`timescale 1ns / 1ps
`default_nettype none

package ftl_pkg;

	localparam int BIN_W      = 32;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int STEP_W     = 6;

	localparam logic [6:0] CH_ZERO  = 7'd48;
	localparam logic [6:0] CH_MEGA  = 7'h4D;
	localparam logic [6:0] CH_KILO  = 7'h6B;
	localparam logic [6:0] CH_DOT   = 7'h2E;
	localparam logic [6:0] CH_SPACE = 7'h20;
	localparam logic [6:0] CH_Z     = 7'h7A;
	localparam logic [6:0] CH_H     = 7'h48;
	localparam logic [6:0] CH_NUL   = 7'h00;

	localparam logic [4:0] POS_PREFIX = 5'd17;
	localparam logic [4:0] POS_NUL    = 5'(56 - 36);
	localparam logic [4:0] POS_Z      = 5'(55 - 36);
	localparam logic [4:0] POS_H      = 5'(54 - 36);

	typedef struct packed {
		logic             start;
		logic             drop;
		logic [BIN_W-1:0] bin;
	} bcd_ctrl_t;

	typedef struct packed {
		logic             busy;
		logic [BCD_W-1:0] bcd;
	} bcd_stat_t;

endpackage

`default_nettype wire

@@ src/frequency_to_lcd_text_writer.sv @@
// Top level: turns a frequency in hertz into a run of LCD commands.
//
//  channel   dir  payload                                         per item
//  s_axis    in   tdata[31:0] frequency                           one beat
//  m_axis    out  tdata: mode, position, character; tlast = last   0 or 5..18 beats
//
// A new value is converted bit-serially, one binary bit per cycle through
// the double dabble register, then one command beat leaves per cycle from
// the output register while m_axis is ready. An item is loaded, shifted
// through every binary bit and leaves the conversion state before its
// beats. A value equal to the stored one is taken and emits nothing.
// Reset clears the stored value to zero and idles the sequencer.
// A stall on m_axis holds the sequencer and the digit register; input is
// taken again once the last beat is in the output register.
`timescale 1ns / 1ps
`default_nettype none

module frequency_to_lcd_text_writer #(
	parameter int TEXT_CHARS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] frequency
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [0] mode, [5:1] position, [12:6] character
	output logic             m_axis_tlast    // last
);

	localparam logic [4:0] TEXT_LAST = 5'(TEXT_CHARS - 1);

	// sequencer codes
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CONV   = 3'd1;
	localparam logic [2:0] ST_CLEAR  = 3'd2;
	localparam logic [2:0] ST_PREFIX = 3'd3;
	localparam logic [2:0] ST_TEXT   = 3'd4;
	localparam logic [2:0] ST_TAIL0  = 3'd5;
	localparam logic [2:0] ST_TAIL1  = 3'd6;
	localparam logic [2:0] ST_TAIL2  = 3'd7;

	logic [2:0]  state_q;
	logic [31:0] last_value_q;
	logic [3:0]  digits_q;   // digit count of the value on show
	logic [3:0]  left_q;     // digits still to write
	logic [1:0]  grp_q;      // digits since the last separator
	logic [1:0]  seps_q;     // separators written so far
	logic [4:0]  tpos_q;     // next text position, counts down

	logic        out_valid_q;
	logic        mode_q;
	logic [4:0]  position_q;
	logic [6:0]  character_q;
	logic        out_last_q;

	ftl_pkg::bcd_ctrl_t bcd_ctrl;
	ftl_pkg::bcd_stat_t bcd_stat;

	logic        in_beat;
	logic        slot_free;
	logic [3:0]  digit_cnt;
	logic        emit_digit;
	logic        sep_dot;

	ftl_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (bcd_ctrl),
		.stat   (bcd_stat)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign slot_free     = !out_valid_q || m_axis_tready;

	// highest nonzero digit sets the count, zero still shows one digit
	always_comb begin
		digit_cnt = 4'd1;
		for (int i = 1; i < ftl_pkg::BCD_DIGITS; i++) begin
			if (bcd_stat.bcd[4*i +: 4] != 4'd0) begin
				digit_cnt = 4'(i + 1);
			end
		end
	end

	// digit beat unless a group of three is complete
	assign emit_digit = (state_q == ST_TEXT) && slot_free && (grp_q != 2'd3);
	// the separator at the unit boundary is a dot: the first one below a
	// million, the second one from a million up
	assign sep_dot    = (digits_q < 4'd7) ? (seps_q == 2'd0) : (seps_q == 2'd1);

	assign bcd_ctrl.start = in_beat && (s_axis_tdata != last_value_q);
	assign bcd_ctrl.bin   = s_axis_tdata;
	assign bcd_ctrl.drop  = emit_digit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			last_value_q <= '0;
			out_valid_q  <= 1'b0;
			digits_q     <= '0;
			left_q       <= '0;
			grp_q        <= '0;
			seps_q       <= '0;
			tpos_q       <= '0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (bcd_ctrl.start) begin
						last_value_q <= s_axis_tdata;
						state_q      <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (!bcd_stat.busy) begin
						state_q <= ST_CLEAR;
					end
				end
				ST_CLEAR: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						digits_q    <= digit_cnt;
						left_q      <= digit_cnt;
						grp_q       <= '0;
						seps_q      <= '0;
						tpos_q      <= TEXT_LAST;
						state_q     <= (digit_cnt >= 4'd4) ? ST_PREFIX : ST_TEXT;
					end
				end
				ST_PREFIX: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_TEXT;
					end
				end
				ST_TEXT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						tpos_q      <= tpos_q - 1'b1;
						if (grp_q == 2'd3) begin
							grp_q  <= '0;
							seps_q <= seps_q + 1'b1;
						end else begin
							grp_q  <= grp_q + 1'b1;
							left_q <= left_q - 1'b1;
							if (left_q == 4'd1) begin
								state_q <= ST_TAIL0;
							end
						end
					end
				end
				ST_TAIL0: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_TAIL1;
					end
				end
				ST_TAIL1: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_TAIL2;
					end
				end
				ST_TAIL2: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload of the output register, loaded whenever a beat is issued
	always_ff @(posedge clk) begin
		if (slot_free) begin
			unique case (state_q)
				ST_CLEAR: begin
					mode_q      <= 1'b0;
					position_q  <= '0;
					character_q <= ftl_pkg::CH_NUL;
					out_last_q  <= 1'b0;
				end
				ST_PREFIX: begin
					mode_q      <= 1'b1;
					position_q  <= ftl_pkg::POS_PREFIX;
					character_q <= (digits_q >= 4'd7) ? ftl_pkg::CH_MEGA : ftl_pkg::CH_KILO;
					out_last_q  <= 1'b0;
				end
				ST_TEXT: begin
					mode_q     <= 1'b1;
					position_q <= tpos_q;
					out_last_q <= 1'b0;
					if (grp_q == 2'd3) begin
						character_q <= sep_dot ? ftl_pkg::CH_DOT : ftl_pkg::CH_SPACE;
					end else begin
						character_q <= ftl_pkg::CH_ZERO + {3'd0, bcd_stat.bcd[3:0]};
					end
				end
				ST_TAIL0: begin
					mode_q      <= 1'b1;
					position_q  <= ftl_pkg::POS_NUL;
					character_q <= ftl_pkg::CH_NUL;
					out_last_q  <= 1'b0;
				end
				ST_TAIL1: begin
					mode_q      <= 1'b1;
					position_q  <= ftl_pkg::POS_Z;
					character_q <= ftl_pkg::CH_Z;
					out_last_q  <= 1'b0;
				end
				ST_TAIL2: begin
					mode_q      <= 1'b1;
					position_q  <= ftl_pkg::POS_H;
					character_q <= ftl_pkg::CH_H;
					out_last_q  <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, character_q, position_q, mode_q};
	assign m_axis_tlast  = out_last_q;

	// the final beat of a run is always the 'H' write
	a_last_is_h: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[12:6] == ftl_pkg::CH_H)
		else $error("final beat is not the H write");

	// digits are read out only after the conversion has finished
	a_text_after_conv: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TEXT |-> !bcd_stat.busy)
		else $error("text readout during conversion");

	// an accepted new value starts the conversion
	a_accept_conv: assert property (@(posedge clk) disable iff (!arst_n)
		bcd_ctrl.start |=> state_q == ST_CONV && bcd_stat.busy)
		else $error("conversion did not start");

	// the digit count never exceeds the ten digits of a 32-bit value
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TEXT |-> digits_q <= 4'd10 && left_q != 4'd0)
		else $error("digit count out of range");

endmodule

`default_nettype wire

@@ src/ftl_bcd.sv @@
// Bit-serial binary to BCD converter with a digit drop shift for readout.
`timescale 1ns / 1ps
`default_nettype none

module ftl_bcd (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ftl_pkg::bcd_ctrl_t ctrl,
	output ftl_pkg::bcd_stat_t      stat
);

	logic [ftl_pkg::BIN_W-1:0]  bin_q;
	logic [ftl_pkg::BCD_W-1:0]  bcd_q;
	logic [ftl_pkg::STEP_W-1:0] cnt_q;
	logic [ftl_pkg::BCD_W-1:0]  adj;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < ftl_pkg::BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.start) begin
			cnt_q <= ftl_pkg::STEP_W'(ftl_pkg::BIN_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			bin_q <= ctrl.bin;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			bin_q <= {bin_q[ftl_pkg::BIN_W-2:0], 1'b0};
			bcd_q <= {adj[ftl_pkg::BCD_W-2:0], bin_q[ftl_pkg::BIN_W-1]};
		end else if (ctrl.drop) begin
			bcd_q <= {4'd0, bcd_q[ftl_pkg::BCD_W-1:4]};
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.bcd  = bcd_q;

endmodule

`default_nettype wire

@@ tb/ftl_lcd_checker.sv @@
// Checker for the frequency to LCD text writer: predicts command beats and compares them.
`timescale 1ns / 1ps

module ftl_lcd_checker #(
	parameter int TEXT_CHARS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [15:0] m_axis_tdata,
	input  wire logic        m_axis_tlast,
	output int               fail_count,
	output int               cmds_pending
);

	localparam logic       MODE_CLEAR = 1'b0;
	localparam logic       MODE_WRITE = 1'b1;

	localparam logic [4:0] SLOT_UNIT  = 5'd17;
	localparam logic [4:0] SLOT_NUL   = 5'd20;
	localparam logic [4:0] SLOT_Z     = 5'd19;
	localparam logic [4:0] SLOT_H     = 5'd18;

	localparam logic [6:0] GLYPH_ZERO  = 7'("0");
	localparam logic [6:0] GLYPH_MEGA  = 7'("M");
	localparam logic [6:0] GLYPH_KILO  = 7'("k");
	localparam logic [6:0] GLYPH_DOT   = 7'(".");
	localparam logic [6:0] GLYPH_SPACE = 7'(" ");
	localparam logic [6:0] GLYPH_Z     = 7'("z");
	localparam logic [6:0] GLYPH_H     = 7'("H");
	localparam logic [6:0] GLYPH_NUL   = 7'd0;

	localparam int PRINT_CAP = 50;

	typedef struct packed {
		logic       mode;
		logic [4:0] slot;
		logic [6:0] glyph;
		logic       fin;
	} lcd_cmd_t;

	lcd_cmd_t    lcd_cmd_q[$];
	logic [31:0] shown_freq = '0;
	int          mism_count = 0;
	int          beats_seen = 0;
	lcd_cmd_t    got_cmd;
	lcd_cmd_t    want_cmd;

	initial begin
		fail_count   = 0;
		cmds_pending = 0;
	end

	task automatic report_mismatch(input string what, input int unsigned got_v,
	                               input int unsigned want_v);
		mism_count++;
		if (mism_count <= PRINT_CAP)
			$display("%0t: beat %0d %s mismatch: got %0d, expected %0d",
			         $time, beats_seen, what, got_v, want_v);
	endtask

	task automatic queue_cmd(input logic mode, input logic [4:0] slot, input logic [6:0] glyph,
	                         input logic fin);
		lcd_cmd_q.push_back({mode, slot, glyph, fin});
	endtask

	// Build the whole command run for one new frequency; a repeat of the shown value is dropped.
	task automatic predict_lcd_run(input logic [31:0] freq);
		logic [6:0]  text_buf [TEXT_CHARS];
		logic [31:0] rem;
		int          n_chars;
		int          n_digits;
		int          in_group;
		int          j;
		if (freq == shown_freq)
			return;
		shown_freq = freq;
		queue_cmd(MODE_CLEAR, 5'd0, GLYPH_NUL, 1'b0);
		// text_buf[0] is the rightmost character on the display
		rem      = freq;
		n_chars  = 0;
		n_digits = 0;
		in_group = 0;
		do begin
			if (in_group == 3) begin
				if (n_chars < TEXT_CHARS) begin
					text_buf[n_chars] = GLYPH_SPACE;
					n_chars++;
				end
				in_group = 0;
			end
			if (n_chars < TEXT_CHARS) begin
				text_buf[n_chars] = GLYPH_ZERO + 7'(rem % 32'd10);
				n_chars++;
			end
			rem = rem / 32'd10;
			n_digits++;
			in_group++;
		end while (rem != 0);
		if (n_digits >= 7) begin
			if (n_chars > 7)
				text_buf[7] = GLYPH_DOT;
			queue_cmd(MODE_WRITE, SLOT_UNIT, GLYPH_MEGA, 1'b0);
		end else if (n_digits >= 4) begin
			if (n_chars > 3)
				text_buf[3] = GLYPH_DOT;
			queue_cmd(MODE_WRITE, SLOT_UNIT, GLYPH_KILO, 1'b0);
		end
		for (j = 0; j < n_chars; j++)
			queue_cmd(MODE_WRITE, 5'(TEXT_CHARS - 1 - j), text_buf[j], 1'b0);
		queue_cmd(MODE_WRITE, SLOT_NUL, GLYPH_NUL, 1'b0);
		queue_cmd(MODE_WRITE, SLOT_Z, GLYPH_Z, 1'b0);
		queue_cmd(MODE_WRITE, SLOT_H, GLYPH_H, 1'b1);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			shown_freq = '0;
			lcd_cmd_q.delete();
		end else begin
			// check the output beat first: it always belongs to an earlier input beat
			if (m_axis_tvalid && m_axis_tready) begin
				got_cmd = {m_axis_tdata[0], m_axis_tdata[5:1], m_axis_tdata[12:6], m_axis_tlast};
				if (lcd_cmd_q.size() == 0) begin
					report_mismatch("unexpected beat", got_cmd, 0);
				end else begin
					want_cmd = lcd_cmd_q.pop_front();
					if (got_cmd.mode !== want_cmd.mode)
						report_mismatch("mode", got_cmd.mode, want_cmd.mode);
					if (got_cmd.slot !== want_cmd.slot)
						report_mismatch("position", got_cmd.slot, want_cmd.slot);
					if (got_cmd.glyph !== want_cmd.glyph)
						report_mismatch("character", got_cmd.glyph, want_cmd.glyph);
					if (got_cmd.fin !== want_cmd.fin)
						report_mismatch("last", got_cmd.fin, want_cmd.fin);
				end
				if (m_axis_tdata[15:13] !== 3'b000)
					report_mismatch("padding", m_axis_tdata[15:13], 0);
				beats_seen++;
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_lcd_run(s_axis_tdata);
		end
		cmds_pending <= lcd_cmd_q.size();
		fail_count   <= mism_count;
	end

endmodule

@@ tb/tb_frequency_to_lcd_text_writer.sv @@
// Testbench top for the frequency to LCD text writer: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 1ps

module tb_frequency_to_lcd_text_writer;

	localparam int TEXT_CHARS   = 16;
	localparam int RANDOM_ITEMS = 420;
	// Output side holds off this long once, so the input side backs up behind it.
	localparam int HOLD_OFF     = 400;
	// Cycles with no beat on either side before the run is declared hung.
	localparam int STALL_LIMIT  = 4000;
	// Quiet cycles after the last expected beat, to catch stray output.
	localparam int DRAIN_CYCLES = 80;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;
	int          fail_count;
	int          cmds_pending;

	int          items_sent    = 0;
	int          gap_free_left = 0;
	int          quiet_cycles  = 0;

	// Corner values: zero right after reset (shows nothing), repeats (show nothing),
	// every digit count at both ends, the unit boundaries and the full 32-bit range.
	logic [31:0] corner_freqs [0:25] = '{
		32'd0, 32'd0, 32'd1, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999,
		32'd1000, 32'd9999, 32'd10000, 32'd99999, 32'd100000, 32'd999999,
		32'd1000000, 32'd9999999, 32'd10000000, 32'd99999999, 32'd100000000,
		32'd999999999, 32'd1000000000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
		32'h8000_0000
	};

	frequency_to_lcd_text_writer #(.TEXT_CHARS(TEXT_CHARS)) dut (.*);

	ftl_lcd_checker #(.TEXT_CHARS(TEXT_CHARS)) lcd_checker (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Idle length: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	// Random frequency: repeats of the previous value, raw 32-bit words, and values
	// spread evenly over the digit counts so every grouping layout shows up.
	function automatic logic [31:0] pick_freq(input logic [31:0] prev);
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned span;
		int              n_digits;
		int              roll;
		roll = $urandom_range(0, 99);
		if (roll < 18)
			return prev;
		if (roll < 33)
			return $urandom;
		n_digits = $urandom_range(1, 10);
		lo = 1;
		repeat (n_digits - 1) lo = lo * 10;
		hi = lo * 10 - 1;
		if (n_digits == 1)
			lo = 0;
		if (hi > 64'hFFFF_FFFF)
			hi = 64'hFFFF_FFFF;
		span = hi - lo + 1;
		return 32'(lo + ({$urandom, $urandom} % span));
	endfunction

	// Offer one frequency beat and hold it until the block takes it. tvalid stays high
	// across back-to-back beats, so it gets at most one update per edge.
	task automatic offer_freq(input logic [31:0] freq);
		int gap;
		if (gap_free_left > 0) begin
			gap = 0;
			gap_free_left--;
		end else begin
			gap = pick_gap();
			if ($urandom_range(0, 99) < 5)
				gap_free_left = $urandom_range(15, 40);
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= freq;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	// Hang detector: count edges at which no beat moves on either channel.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Output side: free-running stretches, short and long random stalls, and one
	// long hold-off while the input side keeps offering beats.
	initial begin
		int  stall;
		bit  squeezed;
		squeezed = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!squeezed && items_sent >= 60) begin
				squeezed = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end else if ($urandom_range(0, 99) < 20) begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(30, 150)) @(posedge clk);
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					m_axis_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	// Input side and verdict.
	initial begin
		logic [31:0] prev_freq;
		prev_freq = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_freqs[i])
			offer_freq(corner_freqs[i]);
		prev_freq = corner_freqs[$size(corner_freqs) - 1];

		repeat (RANDOM_ITEMS) begin
			prev_freq = pick_freq(prev_freq);
			offer_freq(prev_freq);
		end
		s_axis_tvalid <= 1'b0;

		// drain: wait out every expected beat, then watch for stray ones
		do @(posedge clk); while (cmds_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && cmds_pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ files.f @@
src/ftl_pkg.sv
src/ftl_bcd.sv
src/frequency_to_lcd_text_writer.sv
tb/ftl_lcd_checker.sv
tb/tb_frequency_to_lcd_text_writer.sv
